[src/ldpc_cn_pkg.sv]
// Shared types and constants for the min-sum check-node core.
// No dependencies; imported by every module of the block.
package ldpc_cn_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W      = $clog2(MAX_DEGREE);
  localparam int MAG_W      = 7;
  localparam int MSG_W      = 8;
  localparam int POS_W      = 5;

  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(127);

  typedef struct packed {
    logic signed [MSG_W-1:0] in_msg;
    logic                    last_in_row;
  } cn_in_t;

  typedef struct packed {
    logic signed [MSG_W-1:0] out_msg;
    logic [POS_W-1:0]        edge_position;
    logic                    last_out;
  } cn_out_t;

  // Control from the sequencer to the min-tracking unit.
  typedef struct packed {
    logic             load;
    logic             clear;
    logic [IDX_W-1:0] position;
  } cn_upd_t;

  // Row summary held by the min-tracking unit.
  typedef struct packed {
    logic [MAG_W-1:0] min_first;
    logic [MAG_W-1:0] min_second;
    logic [IDX_W-1:0] min_position;
    logic             sign_parity;
  } cn_min_t;

endpackage

[src/ldpc_cn_minfind.sv]
// Min-tracking unit: one compare/update of the two smallest magnitudes per request.
// Depends on ldpc_cn_pkg.
module ldpc_cn_minfind (
  input  logic                          clk,
  input  logic                          rst,
  input  ldpc_cn_pkg::cn_upd_t          upd,
  input  logic [ldpc_cn_pkg::MSG_W-1:0] msg,
  output ldpc_cn_pkg::cn_min_t          row
);
  import ldpc_cn_pkg::*;

  logic             neg;
  logic [MSG_W-1:0] mag_full;
  logic [MAG_W-1:0] mag;
  cn_min_t          row_next;

  assign neg      = msg[MSG_W-1];
  assign mag_full = neg ? (~msg + MSG_W'(1)) : msg;
  // -128 negates to 128, clamp to 127
  assign mag      = mag_full[MSG_W-1] ? MAG_MAX : mag_full[MAG_W-1:0];

  always_comb begin
    row_next             = row;
    row_next.sign_parity = row.sign_parity ^ neg;
    if (mag < row.min_first) begin
      row_next.min_second   = row.min_first;
      row_next.min_first    = mag;
      row_next.min_position = upd.position;
    end else if (mag < row.min_second) begin
      row_next.min_second = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      row.min_first    <= MAG_MAX;
      row.min_second   <= MAG_MAX;
      row.min_position <= '0;
      row.sign_parity  <= 1'b0;
    end else if (upd.load) begin
      row <= row_next;
    end
  end

endmodule

[src/ldpc_min_sum_check_node_core.sv]
// Min-sum check-node core: load sequencer, per-edge sign store and output register.
// Depends on ldpc_cn_pkg and ldpc_cn_minfind.

// A row of d edge messages is taken one message per cycle while msg_valid is
// high (ready stays high while loading); the message flagged last_in_row closes the row.
// The core then drops ready and emits min(d, MAX_DEGREE) results, one per
// cycle while res_ready is high, from a single output register. Messages past
// MAX_DEGREE are dropped but their last flag still ends the row. The next row is
// taken as soon as the previous row's final result sits in the output register.
module ldpc_min_sum_check_node_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_ready,
  input  ldpc_cn_pkg::cn_in_t  msg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ldpc_cn_pkg::cn_out_t res
);
  import ldpc_cn_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] edge_count;
  logic [IDX_W-1:0] emit_idx;
  logic             edge_signs [MAX_DEGREE];

  cn_upd_t          upd;
  cn_min_t          row;

  logic             msg_take;
  logic             has_room;
  logic             out_load;
  logic             emit_last;
  logic [MAG_W-1:0] emit_mag;
  logic             emit_neg;
  logic [MSG_W-1:0] emit_val;

  assign msg_ready = (state == ST_LOAD);
  assign msg_take  = msg_valid && msg_ready;
  assign has_room  = (edge_count < CNT_W'(MAX_DEGREE));
  assign out_load  = (state == ST_EMIT) && (!res_valid || res_ready);
  assign emit_last = ((CNT_W'(emit_idx) + CNT_W'(1)) == edge_count);

  assign upd.load     = msg_take && has_room;
  assign upd.clear    = out_load && emit_last;
  assign upd.position = edge_count[IDX_W-1:0];

  ldpc_cn_minfind u_minfind (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .msg (msg.in_msg),
    .row (row)
  );

  assign emit_mag = (emit_idx == row.min_position) ? row.min_second : row.min_first;
  assign emit_neg = row.sign_parity ^ edge_signs[emit_idx];
  assign emit_val = emit_neg ? (~{1'b0, emit_mag} + MSG_W'(1)) : {1'b0, emit_mag};

  always_ff @(posedge clk) begin
    if (upd.load) begin
      edge_signs[edge_count[IDX_W-1:0]] <= msg.in_msg[MSG_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      edge_count <= '0;
      emit_idx   <= '0;
      res_valid  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (res_valid && res_ready) begin
            res_valid <= 1'b0;
          end
          if (upd.load) begin
            edge_count <= edge_count + CNT_W'(1);
          end
          if (msg_take && msg.last_in_row) begin
            state    <= ST_EMIT;
            emit_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            res_valid <= 1'b1;
            if (emit_last) begin
              state      <= ST_LOAD;
              edge_count <= '0;
            end else begin
              emit_idx <= emit_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.out_msg       <= emit_val;
      res.edge_position <= POS_W'(emit_idx);
      res.last_out      <= emit_last;
    end
  end

endmodule

[src/ldpc_cn_checker.sv]
// Port-level checks for the min-sum check-node core, bound to the top level.
// Depends on ldpc_cn_pkg.
module ldpc_cn_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 msg_valid,
  input logic                 msg_ready,
  input ldpc_cn_pkg::cn_in_t  msg,
  input logic                 res_valid,
  input logic                 res_ready,
  input ldpc_cn_pkg::cn_out_t res
);
  import ldpc_cn_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // closing a row stops intake
  a_row_close: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_ready && msg.last_in_row |=> !msg_ready)
    else $error("request taken after row end");

  // no intake while a row is still being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last_out |-> !msg_ready)
    else $error("ready while row emission pending");

  // results of a row come back to back with rising positions
  a_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res.last_out |=>
      res_valid && (res.edge_position == POS_W'($past(res.edge_position) + POS_W'(1))))
    else $error("result sequence broken");

endmodule

bind ldpc_min_sum_check_node_core ldpc_cn_checker u_ldpc_cn_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_ready (msg_ready),
  .msg       (msg),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

[sim/ldpc_cn_row_checker.sv]
// Checker for the min-sum check-node core: tracks each row as it loads and compares the results.
// Watches both request channels from outside the block; depends only on ldpc_cn_pkg.
module ldpc_cn_row_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  input  logic                 msg_ready,
  input  ldpc_cn_pkg::cn_in_t  msg,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  ldpc_cn_pkg::cn_out_t res,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ldpc_cn_pkg::*;

  logic [MAG_W-1:0] min_first;
  logic [MAG_W-1:0] min_second;
  logic [IDX_W-1:0] min_pos;
  logic             sign_xor;
  logic             edge_sign [MAX_DEGREE];
  logic [CNT_W-1:0] row_edges;
  cn_out_t          c2v_expected [$];
  int               err_count = 0;
  int               res_index = 0;

  task automatic clear_row();
    min_first  = MAG_MAX;
    min_second = MAG_MAX;
    min_pos    = '0;
    sign_xor   = 1'b0;
    row_edges  = '0;
  endtask

  // One result per stored edge: min magnitude, or second min at the min position,
  // signed by the XOR of all the other edges' signs.
  task automatic emit_c2v_row();
    cn_out_t          r;
    logic [MAG_W-1:0] mag;
    logic             neg;
    for (int k = 0; k < row_edges; k++) begin
      mag             = (k == min_pos) ? min_second : min_first;
      neg             = sign_xor ^ edge_sign[k];
      r.out_msg       = neg ? 8'd0 - {1'b0, mag} : {1'b0, mag};
      r.edge_position = POS_W'(k);
      r.last_out      = (k + 1 == row_edges);
      c2v_expected.push_back(r);
    end
    clear_row();
  endtask

  task automatic absorb_v2c(input cn_in_t m);
    logic             neg;
    logic [MSG_W-1:0] mag_raw;
    logic [MAG_W-1:0] mag;
    // edges past the row capacity are dropped, but their last flag still closes the row
    if (row_edges < MAX_DEGREE) begin
      neg     = m.in_msg[MSG_W-1];
      mag_raw = neg ? 8'd0 - m.in_msg : m.in_msg;
      mag     = (mag_raw > MAG_MAX) ? MAG_MAX : mag_raw[MAG_W-1:0];
      sign_xor = sign_xor ^ neg;
      edge_sign[row_edges[IDX_W-1:0]] = neg;
      if (mag < min_first) begin
        min_second = min_first;
        min_first  = mag;
        min_pos    = row_edges[IDX_W-1:0];
      end else if (mag < min_second) begin
        min_second = mag;
      end
      row_edges = row_edges + 1'b1;
    end
    if (m.last_in_row) emit_c2v_row();
  endtask

  always @(posedge clk) begin
    cn_out_t want;
    if (rst) begin
      clear_row();
      c2v_expected.delete();
    end else begin
      if (msg_valid && msg_ready) absorb_v2c(msg);
      if (res_valid && res_ready) begin
        if (c2v_expected.size() == 0) begin
          if (err_count < 10)
            $display("%0t: result %0d with none expected: msg %0d pos %0d last %0b",
                     $realtime, res_index, res.out_msg, res.edge_position, res.last_out);
          err_count++;
        end else begin
          want = c2v_expected.pop_front();
          if (want !== res) begin
            if (err_count < 10)
              $display({"%0t: result %0d mismatch: msg exp %0d got %0d, ",
                        "pos exp %0d got %0d, last exp %0b got %0b"},
                       $realtime, res_index, want.out_msg, res.out_msg,
                       want.edge_position, res.edge_position, want.last_out, res.last_out);
            err_count++;
          end
        end
        res_index++;
      end
    end
    mismatches  <= err_count;
    outstanding <= c2v_expected.size();
  end

endmodule

[sim/tb_ldpc_min_sum_check_node_core.sv]
// Testbench top for ldpc_min_sum_check_node_core: clock, reset, row stimulus and verdict.
// Depends on ldpc_cn_pkg, the core and ldpc_cn_row_checker.
module tb_ldpc_min_sum_check_node_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ldpc_cn_pkg::*;

  localparam int RANDOM_ITEMS = 470;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    msg_valid = 1'b0;
  logic    msg_ready;
  cn_in_t  msg       = '0;
  logic    res_valid;
  logic    res_ready = 1'b0;
  cn_out_t res;

  logic    rx_hold   = 1'b0;
  bit      tx_idles  = 1'b0;
  int      sent      = 0;
  int      cycle_count = 0;
  int      mismatches;
  int      outstanding;

  ldpc_min_sum_check_node_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ldpc_cn_row_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_ready   (msg_ready),
    .msg         (msg),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // valid is only dropped when a gap follows, so it never toggles within one step
  task automatic send_v2c(input logic signed [MSG_W-1:0] v, input logic last);
    int gap;
    gap = tx_idles ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= '{in_msg: v, last_in_row: last};
    do @(posedge clk); while (!msg_ready);
    sent++;
  endtask

  task automatic send_random_row(input int len);
    logic signed [MSG_W-1:0] v;
    bit                      narrow;
    narrow   = $urandom_range(0, 1);
    tx_idles = $urandom_range(0, 3) != 0;
    for (int i = 0; i < len; i++) begin
      // narrow rows keep magnitudes low so ties and repeated minima are frequent
      if (narrow) begin
        v = MSG_W'($urandom_range(0, 12));
        if ($urandom_range(0, 1)) v = -v;
      end else begin
        v = MSG_W'($urandom_range(0, 255));
      end
      send_v2c(v, i == len - 1);
    end
  endtask

  initial begin
    int base;
    int len;
    int pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes, zero and the most negative code
    send_v2c(0, 1'b0);
    send_v2c(-128, 1'b0);
    send_v2c(127, 1'b0);
    send_v2c(-1, 1'b0);
    send_v2c(1, 1'b1);
    // single-edge row
    send_v2c(-5, 1'b1);
    // tie on the minimum
    tx_idles = 1'b1;
    send_v2c(3, 1'b0);
    send_v2c(-3, 1'b0);
    send_v2c(3, 1'b0);
    send_v2c(10, 1'b1);
    // nothing below full scale
    send_v2c(127, 1'b0);
    send_v2c(-127, 1'b0);
    send_v2c(-128, 1'b1);
    // zero minimum, tied
    tx_idles = 1'b0;
    send_v2c(0, 1'b0);
    send_v2c(0, 1'b0);
    send_v2c(-64, 1'b1);
    send_v2c(64, 1'b0);
    send_v2c(-32, 1'b1);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        len = $urandom_range(MAX_DEGREE + 1, MAX_DEGREE + 8);
      else if (pick < 4)
        len = $urandom_range(13, MAX_DEGREE);
      else if (pick == 4)
        len = 1;
      else
        len = $urandom_range(2, 12);
      send_random_row(len);
    end
    msg_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // result side: random per-result waits, in bursts with and without idling
  initial begin
    int gap;
    int burst;
    bit rx_idles;
    burst    = 0;
    rx_idles = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (burst == 0) begin
        rx_idles = $urandom_range(0, 2) != 0;
        burst    = $urandom_range(10, 60);
      end
      burst--;
      gap = rx_idles ? $urandom_range(0, 7) : 0;
      if (gap > 0 || rx_hold) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // long back-pressure early in the random part; the sender keeps offering requests
  initial begin
    @(posedge clk);
    while (sent < 40) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
